// ----- design/idbf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idbf_pkg
// Shared types and constants of the duplicate box filter.
// ----------------------------------------------------------------------------
package idbf_pkg;

   // threshold fraction registers
   localparam int RATIO_W = 10;

   // register indexes on the CSR port (byte address / 4)
   localparam logic REG_RATIO_NUM = 1'b0;
   localparam logic REG_RATIO_DEN = 1'b1;

   // reset values of the threshold fraction
   localparam logic [RATIO_W-1:0] RATIO_NUM_RST = 10'd7;
   localparam logic [RATIO_W-1:0] RATIO_DEN_RST = 10'd10;

   // register stages from ring head to hit flag in the overlap unit
   localparam int IOU_LAT = 5;

   // per-cell control of the box ring
   typedef struct packed {
      logic shift;   // rotate ring by one cell
      logic load;    // write the candidate box into this cell
   } cell_ctl_type;

endpackage

// ----- design/idbf_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idbf_cell
// One cell of the kept-box ring: holds one box, rotates to its neighbor.
// ----------------------------------------------------------------------------
module idbf_cell #(
   parameter int BOX_W = 48
) (
   input  logic                  clock,
   input  idbf_pkg::cell_ctl_type ctl,
   input  logic [BOX_W-1:0]      shift_in,
   input  logic [BOX_W-1:0]      load_data,
   output logic [BOX_W-1:0]      box_out
);
   import idbf_pkg::*;

   logic [BOX_W-1:0] box_ff;
   logic [BOX_W-1:0] box_in;

   // load wins over rotation; the two never coincide
   always_comb begin
      priority if (ctl.load) begin
         box_in = load_data;
      end else if (ctl.shift) begin
         box_in = shift_in;
      end else begin
         box_in = box_ff;
      end
   end

   always_ff @(posedge clock) begin
      box_ff <= box_in;
   end

   assign box_out = box_ff;

endmodule

// ----- design/idbf_iou.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idbf_iou
// Pipelined overlap test: inter*den > num*union, one box pair per cycle.
// ----------------------------------------------------------------------------
module idbf_iou #(
   parameter int CB = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pair_valid,
   input  logic [4*CB-1:0]               box_a,
   input  logic [4*CB-1:0]               box_b,
   input  logic [idbf_pkg::RATIO_W-1:0]  ratio_num,
   input  logic [idbf_pkg::RATIO_W-1:0]  ratio_den,
   output logic                          hit
);
   import idbf_pkg::*;

   localparam int PW = 2*CB + 2;   // signed product width
   localparam int UW = 2*CB + 4;   // signed union sum width
   localparam int IW = 2*CB;       // intersection magnitude
   localparam int NW = 2*CB + 1;   // positive union magnitude
   localparam int LW = IW + RATIO_W;
   localparam int RW = NW + RATIO_W;

   logic [CB-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
   logic [CB-1:0] il, it, ir, ib;

   // stage 1: edges and spans
   logic              v1_ff, v1_in;
   logic              nx1_ff, nx1_in;
   logic signed [CB:0] w_ff, h_ff, wa_ff, ha_ff, wb_ff, hb_ff;
   logic signed [CB:0] w_in, h_in, wa_in, ha_in, wb_in, hb_in;
   // stage 2: areas
   logic              v2_ff, nx2_ff;
   logic signed [PW-1:0] it_ff, aa_ff, ab_ff, it_in, aa_in, ab_in;
   // stage 3: union
   logic              ok3_ff, ok3_in;
   logic [IW-1:0]     inter3_ff;
   logic [NW-1:0]     uni3_ff;
   logic signed [UW-1:0] uni_sum;
   // stage 4: cross products
   logic              ok4_ff;
   logic [LW-1:0]     lhs_ff, lhs_in;
   logic [RW-1:0]     rhs_ff, rhs_in;
   // stage 5: decision
   logic              hit_ff, hit_in;

   assign {ay2, ax2, ay1, ax1} = box_a;
   assign {by2, bx2, by1, bx1} = box_b;

   // intersection edges and signed spans
   always_comb begin
      il     = (ax1 > bx1) ? ax1 : bx1;
      it     = (ay1 > by1) ? ay1 : by1;
      ir     = (ax2 < bx2) ? ax2 : bx2;
      ib     = (ay2 < by2) ? ay2 : by2;
      v1_in  = pair_valid;
      nx1_in = (il >= ir) || (it >= ib);
      w_in   = $signed({1'b0, ir}) - $signed({1'b0, il});
      h_in   = $signed({1'b0, ib}) - $signed({1'b0, it});
      wa_in  = $signed({1'b0, ax2}) - $signed({1'b0, ax1});
      ha_in  = $signed({1'b0, ay2}) - $signed({1'b0, ay1});
      wb_in  = $signed({1'b0, bx2}) - $signed({1'b0, bx1});
      hb_in  = $signed({1'b0, by2}) - $signed({1'b0, by1});
   end

   // areas
   always_comb begin
      it_in = w_ff * h_ff;
      aa_in = wa_ff * ha_ff;
      ab_in = wb_ff * hb_ff;
   end

   // union, and whether the pair can match at all
   always_comb begin
      uni_sum = {{2{aa_ff[PW-1]}}, aa_ff} + {{2{ab_ff[PW-1]}}, ab_ff}
              - {{2{it_ff[PW-1]}}, it_ff};
      ok3_in  = v2_ff && !nx2_ff && !uni_sum[UW-1] && (uni_sum != '0);
   end

   // cross products of the threshold test
   always_comb begin
      lhs_in = LW'(inter3_ff) * LW'(ratio_den);
      rhs_in = RW'(uni3_ff) * RW'(ratio_num);
   end

   assign hit_in = ok4_ff && ({{(RW-LW){1'b0}}, lhs_ff} > rhs_ff);

   // control of the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         ok3_ff <= 1'b0;
         ok4_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         v1_ff  <= v1_in;
         v2_ff  <= v1_ff;
         ok3_ff <= ok3_in;
         ok4_ff <= ok3_ff;
         hit_ff <= hit_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      nx1_ff    <= nx1_in;
      w_ff      <= w_in;
      h_ff      <= h_in;
      wa_ff     <= wa_in;
      ha_ff     <= ha_in;
      wb_ff     <= wb_in;
      hb_ff     <= hb_in;
      nx2_ff    <= nx1_ff;
      it_ff     <= it_in;
      aa_ff     <= aa_in;
      ab_ff     <= ab_in;
      inter3_ff <= it_ff[IW-1:0];
      uni3_ff   <= uni_sum[NW-1:0];
      lhs_ff    <= lhs_in;
      rhs_ff    <= rhs_in;
   end

   assign hit = hit_ff;

endmodule

// ----- design/iou_duplicate_box_filter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iou_duplicate_box_filter_core
// Greedy IoU duplicate filter over a ring of kept boxes.
// ----------------------------------------------------------------------------
// One box is handled at a time. The kept boxes sit in a ring of MAX_KEPT
// cells that, while a box is scanned, rotates one cell per cycle past a
// single pipelined overlap unit. Each box passes a full ring turn and the
// 5-stage overlap pipe before its result is registered, independent of how
// many boxes are kept. The result sits in an output register; the next box
// is taken in the cycle after the result is registered, so a new box is
// never accepted before the last one is through.
// A previous result still waiting on rsp_tready holds the finished box back.
// A box whose overlap with a kept box exceeds ratio_num/ratio_den is
// flagged as a duplicate; a unique box is appended to the ring, or flagged
// store_full if the ring is full. end_of_set empties the ring afterwards.
// ----------------------------------------------------------------------------
module iou_duplicate_box_filter_core #(
   parameter int MAX_KEPT   = 64,
   parameter int COORD_BITS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   // box input
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // left_x, top_y, right_x, bottom_y, zero pad
   input  logic [((4*COORD_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                    req_tlast,   // end_of_set
   // result output
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // out_left_x, out_top_y, out_right_x, out_bottom_y, zero pad
   output logic [((4*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic [1:0]              rsp_tuser,   // keep, store_full
   output logic                    rsp_tlast,   // out_end_of_set
   // register port
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [2:0]              csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   import idbf_pkg::*;

   localparam int BOX_W = 4*COORD_BITS;
   localparam int DW    = ((BOX_W+7)/8)*8;
   localparam int KW    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CW    = $clog2(MAX_KEPT+1);
   localparam int LTW   = $clog2(IOU_LAT);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [KW-1:0]      pos_ff, pos_in;
   logic [LTW-1:0]     drain_ff, drain_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               dup_ff, dup_in;
   logic [BOX_W-1:0]   cand_ff, cand_in;
   logic               eos_ff, eos_in;
   logic [RATIO_W-1:0] num_ff, num_in, den_ff, den_in;
   logic               rv_ff, rv_in;
   logic [BOX_W-1:0]   rbox_ff, rbox_in;
   logic               rkeep_ff, rkeep_in, rfull_ff, rfull_in, rlast_ff, rlast_in;

   logic               req_xfer, finish, store_room, pair_valid, hit, shift;
   logic [BOX_W-1:0]   ring [MAX_KEPT];
   cell_ctl_type       ctl [MAX_KEPT];

   // register port
   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_RATIO_NUM: num_in = csr_pwdata[RATIO_W-1:0];
            REG_RATIO_DEN: den_in = csr_pwdata[RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_RATIO_NUM: csr_prdata = {{(32-RATIO_W){1'b0}}, num_ff};
         REG_RATIO_DEN: csr_prdata = {{(32-RATIO_W){1'b0}}, den_ff};
         default:       csr_prdata = '0;
      endcase
   end

   // ring of kept boxes, head is cell 0
   assign shift      = (state_ff == ST_SCAN);
   assign store_room = (count_ff < CW'(MAX_KEPT));
   assign finish     = (state_ff == ST_DONE) && (!rv_ff || rsp_tready);

   for (genvar g = 0; g < MAX_KEPT; g++) begin : g_ring
      always_comb begin
         ctl[g].shift = shift;
         ctl[g].load  = finish && !dup_ff && store_room
                        && (count_ff[KW-1:0] == KW'(g));
      end
      idbf_cell #(.BOX_W(BOX_W)) u_cell (
         .clock     (clock),
         .ctl       (ctl[g]),
         .shift_in  (ring[(g+1) % MAX_KEPT]),
         .load_data (cand_ff),
         .box_out   (ring[g])
      );
   end

   // overlap unit on the ring head
   assign pair_valid = shift && (CW'(pos_ff) < count_ff);

   idbf_iou #(.CB(COORD_BITS)) u_iou (
      .clock      (clock),
      .reset      (reset),
      .pair_valid (pair_valid),
      .box_a      (cand_ff),
      .box_b      (ring[0]),
      .ratio_num  (num_ff),
      .ratio_den  (den_ff),
      .hit        (hit)
   );

   // sequencer
   assign req_xfer   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      drain_in = drain_ff;
      count_in = count_ff;
      dup_in   = dup_ff || hit;
      cand_in  = cand_ff;
      eos_in   = eos_ff;
      rv_in    = rv_ff && !rsp_tready;
      rbox_in  = rbox_ff;
      rkeep_in = rkeep_ff;
      rfull_in = rfull_ff;
      rlast_in = rlast_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cand_in  = req_tdata[BOX_W-1:0];
               eos_in   = req_tlast;
               dup_in   = 1'b0;
               pos_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            pos_in = pos_ff + 1'b1;
            if (pos_ff == KW'(MAX_KEPT-1)) begin
               pos_in   = '0;
               drain_in = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + 1'b1;
            if (drain_ff == LTW'(IOU_LAT-1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (finish) begin
               rv_in    = 1'b1;
               rbox_in  = cand_ff;
               rkeep_in = !dup_ff;
               rfull_in = !dup_ff && !store_room;
               rlast_in = eos_ff;
               if (!dup_ff && store_room) begin
                  count_in = count_ff + 1'b1;
               end
               if (eos_ff) begin
                  count_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         drain_ff <= '0;
         count_ff <= '0;
         dup_ff   <= 1'b0;
         rv_ff    <= 1'b0;
         num_ff   <= RATIO_NUM_RST;
         den_ff   <= RATIO_DEN_RST;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         drain_ff <= drain_in;
         count_ff <= count_in;
         dup_ff   <= dup_in;
         rv_ff    <= rv_in;
         num_ff   <= num_in;
         den_ff   <= den_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cand_ff  <= cand_in;
      eos_ff   <= eos_in;
      rbox_ff  <= rbox_in;
      rkeep_ff <= rkeep_in;
      rfull_ff <= rfull_in;
      rlast_ff <= rlast_in;
   end

   // result channel
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = DW'(rbox_ff);
   assign rsp_tuser  = {rfull_ff, rkeep_ff};
   assign rsp_tlast  = rlast_ff;

endmodule
